// ----- design/lzg1_pkg.sv -----
// ---------------------------------------------------------------------------
// lzg1_pkg
// Shared types, constants and the length table of the LZG1 decompressor.
// ---------------------------------------------------------------------------
`default_nettype none
package lzg1_pkg;

  localparam int unsigned HIST_AW      = 20;
  localparam int unsigned HIST_DEPTH   = 1 << HIST_AW;
  localparam int unsigned OFF_W        = 20;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = 2;

  localparam logic [7:0]  METHOD_COPY  = 8'd0;
  localparam logic [7:0]  METHOD_LZG1  = 8'd1;
  localparam logic [OFF_W-1:0] DIST_BASE  = OFF_W'(2056);
  localparam logic [OFF_W-1:0] SHORT_BASE = OFF_W'(8);

  typedef enum logic [2:0] {
    PH_HEADER, PH_MARKERS, PH_SYMBOL, PH_PARAM,
    PH_DISTANT, PH_MEDIUM, PH_PLAIN, PH_IGNORE
  } phase_t;

  typedef enum logic [1:0] {CMD_LIT, CMD_COPY, CMD_EMPTY} cmd_kind_t;

  typedef enum logic [2:0] {B_IDLE, B_LIT, B_RD, B_WR, B_EMIT} bstate_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [OFF_W-1:0] off;
    logic [7:0]       len;
    logic             last;
    logic             bad;
    logic [31:0]      size;
  } cmd_t;

  function automatic logic [7:0] len_lookup(input logic [4:0] code);
    logic [7:0] v;
    case (code)
      5'd28:   v = 8'd35;
      5'd29:   v = 8'd48;
      5'd30:   v = 8'd72;
      5'd31:   v = 8'd128;
      default: v = 8'({3'b000, code}) + 8'd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/lzg1_ram.sv -----
// ---------------------------------------------------------------------------
// lzg1_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module lzg1_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule
`default_nettype wire

// ----- design/lzg1_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// lzg1_cmd_fifo
// Short command queue between the parser and the copy engine.
// ---------------------------------------------------------------------------
`default_nettype none
module lzg1_cmd_fifo import lzg1_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);
  cmd_t               ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + FIFO_AW'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

// ----- design/lzg1_parser.sv -----
// ---------------------------------------------------------------------------
// lzg1_parser
// Front end: parse header and markers, classify each later byte into at most one command.
// ---------------------------------------------------------------------------
`default_nettype none
module lzg1_parser import lzg1_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  input  wire logic [31:0] capacity,
  input  wire logic        q_full,
  output logic             push,
  output cmd_t             push_cmd
);
  phase_t           phase_r, phase_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [3:0][7:0]  mark_r, mark_nxt;
  logic [7:0]       psym_r, psym_nxt;
  logic [7:0]       p0_r, p0_nxt, p1_r, p1_nxt;
  logic             dsec_r, dsec_nxt;
  logic [31:0]      prod_r, prod_nxt;

  logic             acc, is_mark, do_copy;
  logic [OFF_W-1:0] c_off;
  logic [7:0]       c_len;
  logic             c_bad;
  logic [32:0]      prod_sum;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign is_mark   = (in_tdata == mark_r[0]) || (in_tdata == mark_r[1]) ||
                     (in_tdata == mark_r[2]) || (in_tdata == mark_r[3]);

  function automatic logic [31:0] size_nxt_report();
    logic [31:0] s;
    s = size_r;
    if (phase_r == PH_HEADER && cnt_r >= 4'd3 && cnt_r <= 4'd6) s = {size_r[23:0], in_tdata};
    return s;
  endfunction

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (cnt_r == 4'(HEADER_BYTES - 1)) begin
            phase_nxt = (in_tdata == METHOD_LZG1) ? PH_MARKERS :
                        (in_tdata == METHOD_COPY) ? PH_PLAIN : PH_IGNORE;
          end
        end
        PH_MARKERS: if (cnt_r == 4'd3) phase_nxt = PH_SYMBOL;
        PH_SYMBOL:  if (is_mark) phase_nxt = PH_PARAM;
        PH_PARAM: begin
          phase_nxt = PH_SYMBOL;
          if (in_tdata != 8'd0 && psym_r == mark_r[0]) phase_nxt = PH_DISTANT;
          else if (in_tdata != 8'd0 && psym_r == mark_r[1]) phase_nxt = PH_MEDIUM;
        end
        PH_DISTANT: if (dsec_r) phase_nxt = PH_SYMBOL;
        PH_MEDIUM:  phase_nxt = PH_SYMBOL;
        default:    phase_nxt = phase_r;
      endcase
      if (in_tlast) phase_nxt = PH_HEADER;
    end
  end

  // Datapath and command
  always_comb begin
    cnt_nxt  = cnt_r;
    size_nxt = size_r;
    mark_nxt = mark_r;
    psym_nxt = psym_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    dsec_nxt = dsec_r;
    prod_nxt = prod_r;
    push     = 1'b0;
    push_cmd = '0;
    do_copy  = 1'b0;
    c_off    = '0;
    c_len    = '0;
    if (acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (cnt_r >= 4'd3 && cnt_r <= 4'd6) size_nxt = {size_r[23:0], in_tdata};
          cnt_nxt = (cnt_r == 4'(HEADER_BYTES - 1)) ? 4'd0 : cnt_r + 4'd1;
        end
        PH_MARKERS: begin
          mark_nxt[cnt_r[1:0]] = in_tdata;
          cnt_nxt = (cnt_r == 4'd3) ? 4'd0 : cnt_r + 4'd1;
        end
        PH_SYMBOL: begin
          if (is_mark) begin
            psym_nxt = in_tdata;
          end else begin
            push = 1'b1;
            push_cmd.kind = CMD_LIT;
            push_cmd.data = in_tdata;
          end
        end
        PH_PARAM: begin
          if (in_tdata == 8'd0) begin
            push = 1'b1;
            push_cmd.kind = CMD_LIT;
            push_cmd.data = psym_r;
          end else if (psym_r == mark_r[0]) begin
            p0_nxt   = in_tdata;
            dsec_nxt = 1'b0;
          end else if (psym_r == mark_r[1]) begin
            p0_nxt = in_tdata;
          end else if (psym_r == mark_r[2]) begin
            do_copy = 1'b1;
            c_off   = OFF_W'(in_tdata[5:0]) + SHORT_BASE;
            c_len   = 8'(in_tdata[7:6]) + 8'd3;
          end else begin
            do_copy = 1'b1;
            c_off   = OFF_W'(in_tdata[7:5]) + OFF_W'(1);
            c_len   = len_lookup(in_tdata[4:0]);
          end
        end
        PH_DISTANT: begin
          if (!dsec_r) begin
            p1_nxt   = in_tdata;
            dsec_nxt = 1'b1;
          end else begin
            dsec_nxt = 1'b0;
            do_copy  = 1'b1;
            c_off    = OFF_W'({p0_r[7:5], p1_r, in_tdata}) + DIST_BASE;
            c_len    = len_lookup(p0_r[4:0]);
          end
        end
        PH_MEDIUM: begin
          do_copy = 1'b1;
          c_off   = OFF_W'({p0_r[7:5], in_tdata}) + SHORT_BASE;
          c_len   = len_lookup(p0_r[4:0]);
        end
        PH_PLAIN: begin
          if (prod_r < capacity) begin
            push = 1'b1;
            push_cmd.kind = CMD_LIT;
            push_cmd.data = in_tdata;
          end
        end
        default: ;
      endcase
    end

    c_bad    = (32'(c_off) > prod_r) || (32'(c_off) > 32'(HIST_DEPTH));
    prod_sum = {1'b0, prod_r} + 33'(c_len);
    if (do_copy) begin
      push = 1'b1;
      push_cmd.kind = c_bad ? CMD_EMPTY : CMD_COPY;
      push_cmd.off  = c_off;
      push_cmd.len  = c_len;
      push_cmd.bad  = c_bad;
      if (!c_bad) prod_nxt = prod_sum[32] ? 32'hFFFF_FFFF : prod_sum[31:0];
    end else if (push && prod_r != 32'hFFFF_FFFF) begin
      prod_nxt = prod_r + 32'd1;
    end

    if (acc && in_tlast) begin
      if (!push) begin
        push = 1'b1;
        push_cmd.kind = CMD_EMPTY;
      end
      cnt_nxt  = '0;
      size_nxt = '0;
      mark_nxt = '0;
      psym_nxt = '0;
      p0_nxt   = '0;
      p1_nxt   = '0;
      dsec_nxt = 1'b0;
      prod_nxt = '0;
    end
    push_cmd.last = acc && in_tlast;
    push_cmd.size = size_nxt_report();
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      size_r  <= '0;
      mark_r  <= '0;
      psym_r  <= '0;
      p0_r    <= '0;
      p1_r    <= '0;
      dsec_r  <= 1'b0;
      prod_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      size_r  <= size_nxt;
      mark_r  <= mark_nxt;
      psym_r  <= psym_nxt;
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      dsec_r  <= dsec_nxt;
      prod_r  <= prod_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/lzg1_copier.sv -----
// ---------------------------------------------------------------------------
// lzg1_copier
// Back end: write literals to history, copy back-references, pack results.
// ---------------------------------------------------------------------------
`default_nettype none
module lzg1_copier import lzg1_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cmd_t  head,
  input  wire logic  q_empty,
  output logic       pop,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output logic [3:0][7:0] out_bytes,
  output logic [2:0] out_count,
  output logic       out_run_end,
  output logic       out_done,
  output logic [31:0] out_size,
  output logic       out_status
);
  bstate_t            st_r, st_nxt;
  cmd_t               cur_r, cur_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic               end_r, end_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [3:0][7:0]    pack_r, pack_nxt;
  logic [2:0]         pcnt_r, pcnt_nxt;
  logic               ov_r, ov_nxt;
  logic [3:0][7:0]    ob_r, ob_nxt;
  logic [2:0]         oc_r, oc_nxt;
  logic               ore_r, ore_nxt, od_r, od_nxt, ost_r, ost_nxt;
  logic [31:0]        osz_r, osz_nxt;

  logic               we, out_free;
  logic [7:0]         wd, rdata;
  logic [HIST_AW-1:0] ra;

  assign out_free = !ov_r || out_tready;
  assign ra       = wp_r - cur_r.off[HIST_AW-1:0];

  lzg1_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(we), .wa(wp_r), .wd(wd), .ra(ra), .rd(rdata)
  );

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (head.kind)
            CMD_LIT:  st_nxt = B_LIT;
            CMD_COPY: st_nxt = B_RD;
            default:  st_nxt = B_EMIT;
          endcase
        end
      end
      B_LIT:  st_nxt = B_EMIT;
      B_RD:   st_nxt = B_WR;
      B_WR:   st_nxt = (pcnt_r == 3'd3 || rem_r == 8'd1) ? B_EMIT : B_RD;
      B_EMIT: if (out_free) st_nxt = end_r ? B_IDLE : B_RD;
      default: st_nxt = B_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    cur_nxt  = cur_r;
    rem_nxt  = rem_r;
    end_nxt  = end_r;
    wp_nxt   = wp_r;
    pack_nxt = pack_r;
    pcnt_nxt = pcnt_r;
    ov_nxt   = ov_r && !out_tready;
    ob_nxt   = ob_r;
    oc_nxt   = oc_r;
    ore_nxt  = ore_r;
    od_nxt   = od_r;
    ost_nxt  = ost_r;
    osz_nxt  = osz_r;
    pop      = 1'b0;
    we       = 1'b0;
    wd       = cur_r.data;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          rem_nxt = head.len;
          end_nxt = (head.kind == CMD_EMPTY);
        end
      end
      B_LIT: begin
        we       = 1'b1;
        wp_nxt   = wp_r + HIST_AW'(1);
        pack_nxt[pcnt_r[1:0]] = cur_r.data;
        pcnt_nxt = pcnt_r + 3'd1;
        end_nxt  = 1'b1;
      end
      B_WR: begin
        we       = 1'b1;
        wd       = rdata;
        wp_nxt   = wp_r + HIST_AW'(1);
        pack_nxt[pcnt_r[1:0]] = rdata;
        pcnt_nxt = pcnt_r + 3'd1;
        rem_nxt  = rem_r - 8'd1;
        end_nxt  = (rem_r == 8'd1);
      end
      B_EMIT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ob_nxt   = pack_r;
          oc_nxt   = pcnt_r;
          ore_nxt  = end_r;
          od_nxt   = end_r && cur_r.last;
          ost_nxt  = cur_r.bad;
          osz_nxt  = cur_r.size;
          pack_nxt = '0;
          pcnt_nxt = '0;
          if (end_r && cur_r.last) wp_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      end_r  <= 1'b0;
      wp_r   <= '0;
      pack_r <= '0;
      pcnt_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      end_r  <= end_nxt;
      wp_r   <= wp_nxt;
      pack_r <= pack_nxt;
      pcnt_r <= pcnt_nxt;
      ov_r   <= ov_nxt;
    end
    cur_r <= cur_nxt;
    rem_r <= rem_nxt;
    ob_r  <= ob_nxt;
    oc_r  <= oc_nxt;
    ore_r <= ore_nxt;
    od_r  <= od_nxt;
    ost_r <= ost_nxt;
    osz_r <= osz_nxt;
  end

  assign out_tvalid  = ov_r;
  assign out_bytes   = ob_r;
  assign out_count   = oc_r;
  assign out_run_end = ore_r;
  assign out_done    = od_r;
  assign out_size    = osz_r;
  assign out_status  = ost_r;

  a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n) pcnt_r <= 3'd4)
    else $error("pack count overflow");
  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_RD |=> st_r == B_WR)
    else $error("history read not followed by write");
  a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_RD |-> rem_r != 8'd0)
    else $error("copy read with nothing left");
endmodule
`default_nettype wire

// ----- design/lzg1_stream_decompressor_unit.sv -----
// ---------------------------------------------------------------------------
// lzg1_stream_decompressor_unit
// LZG1 stream decompressor: byte stream in, packed decoded words out.
// ---------------------------------------------------------------------------
// Header, marker and parameter bytes are accepted while the queue is not full;
//   a literal passes through dequeue, history write and emit in the engine, and
//   a 4-entry queue absorbs bursts. Back-references: a dequeue, a registered
//   history read then a write per copied byte, and an emit per output word of
//   up to four bytes.
// Reset: synchronous active low; history is not cleared, only read after written.
`default_nettype none
module lzg1_stream_decompressor_unit import lzg1_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,   // output_capacity
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // data_byte
  input  wire logic        in_tlast,      // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] out_byte_0, [15:8] out_byte_1, [23:16] out_byte_2, [31:24] out_byte_3,
  // [34:32] valid_count, [66:35] header_size, [71:67] zero
  output logic [71:0]      out_tdata,
  output logic             out_tlast,     // run_end
  output logic [1:0]       out_tuser      // [0] stream_done, [1] status
);
  logic [31:0]     cap_r;
  logic            q_push, q_pop, q_full, q_empty;
  cmd_t            q_in, q_head;
  logic [3:0][7:0] o_bytes;
  logic [2:0]      o_count;
  logic            o_done, o_status;
  logic [31:0]     o_size;

  // Capacity register; the user must write it only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 32'hFFFF_FFFF;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Front: classify each byte into at most one command.
  lzg1_parser u_parser (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .capacity(cap_r), .q_full(q_full),
    .push(q_push), .push_cmd(q_in)
  );

  // Decouple the parser from the copy engine.
  lzg1_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_cmd(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  // Back: history writes, copies and word packing.
  lzg1_copier u_copier (
    .clk(clk), .rst_n(rst_n),
    .head(q_head), .q_empty(q_empty), .pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_bytes(o_bytes), .out_count(o_count), .out_run_end(out_tlast),
    .out_done(o_done), .out_size(o_size), .out_status(o_status)
  );

  assign out_tdata = {5'b00000, o_size, o_count, o_bytes};
  assign out_tuser = {o_status, o_done};
endmodule
`default_nettype wire
